@@ src/dcm_pkg.sv @@
// types and constants shared by the timed move controller and its checker
`default_nettype none

package dcm_pkg;

  localparam int POS_W    = 16;
  localparam int TIME_W   = 32;
  localparam int SPEED_W  = 24;
  localparam int TRAVEL_W = SPEED_W + TIME_W;
  localparam int CMP_W    = TRAVEL_W + 2;
  localparam int SPAN_W   = POS_W + 1;
  localparam int LIM_W    = SPAN_W + 19;

  // 1000 ms per second times 256 for the speed fraction, split as 125 << 11
  localparam int FRAC_SHIFT = 11;
  localparam int DIV_ODD    = 125;
  localparam int DIVISOR    = DIV_ODD << FRAC_SHIFT;

  // quotient by 125 through a reciprocal, exact for the travel range that can pass the compare
  localparam int QSRC_HI     = 33;
  localparam int QSRC_W      = QSRC_HI - FRAC_SHIFT + 1;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam int RPROD_W     = QSRC_W + RECIP_W;
  localparam int QUOT_W      = RPROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(8589935);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_SET  = 2'd2,
    OP_STOP = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PH_DONE = 2'd0,
    PH_INIT = 2'd1,
    PH_EXEC = 2'd2
  } phase_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic signed [POS_W-1:0]  value;
    logic [TIME_W-1:0]        now_ms;
    logic                     home_override;
  } in_word_t;

  typedef struct packed {
    logic                     drive_a;
    logic                     drive_b;
    logic signed [POS_W-1:0]  position;
    logic                     finished;
  } out_word_t;

  // x times the divisor, by shifts and subtracts
  function automatic logic signed [LIM_W-1:0] mul_div(input logic signed [SPAN_W-1:0] x);
    logic signed [LIM_W-1:0] xe;
    xe = {{(LIM_W-SPAN_W){x[SPAN_W-1]}}, x};
    return (xe <<< 18) - (xe <<< 12) - (xe <<< FRAC_SHIFT);
  endfunction

endpackage

`default_nettype wire

@@ src/dc_motor_timed_move_controller.sv @@
// pipeline: stage a registers the input word and its travel product, then the
// result register takes the result word; one word per cycle while the receiver does
// not stall; the divide by 256000 and the target compare work between the two registers
// reset: synchronous, clears the controller to done with the bridge low, speed to zero
// and both pipeline stages to empty; no clearing pass
`default_nettype none

module dc_motor_timed_move_controller (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  dcm_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output dcm_pkg::out_word_t            out_data,
  input  wire                           cfg_we,
  input  wire [dcm_pkg::SPEED_W-1:0]    cfg_data
);
  import dcm_pkg::*;

  logic [SPEED_W-1:0]       speed;
  phase_t                   phase, phase_next;
  logic                     dir_forward, dir_forward_next;
  logic signed [POS_W-1:0]  target_pos, target_pos_next;
  logic signed [POS_W-1:0]  current_pos, current_pos_next;
  logic signed [POS_W-1:0]  start_pos, start_pos_next;
  logic [TIME_W-1:0]        start_time, start_time_next;
  logic                     pin_a, pin_a_next;
  logic                     pin_b, pin_b_next;
  logic signed [LIM_W-1:0]  thr, thr_next;
  logic signed [LIM_W-1:0]  lim, lim_next;

  logic                     valid_a;
  in_word_t                 item_a;
  logic [TRAVEL_W-1:0]      travel_a;

  logic                     accept;
  logic                     adv;
  logic                     fwd_init;
  logic [TIME_W-1:0]        start_eff;
  logic [TIME_W-1:0]        elapsed;
  logic [TRAVEL_W-1:0]      travel_next;

  logic signed [CMP_W-1:0]  tw, thr_x, lim_x;
  logic                     ok_floor, ok_ceil, use_ceil, ok;
  logic [QSRC_W-1:0]        qsrc;
  logic [RPROD_W-1:0]       rprod;
  logic [QUOT_W-1:0]        quot;
  logic [QSRC_W:0]          quot125;
  logic                     rem_nz;
  logic [QUOT_W-1:0]        adj;
  logic signed [POS_W-1:0]  est;
  logic signed [SPAN_W-1:0] cur_x, tgt_x, span, base;

  // handshake: stage a moves on when the result register is free or being taken
  assign adv      = valid_a && (!out_valid || !out_stall);
  assign in_stall = rst || (valid_a && !adv);
  assign accept   = in_valid && !in_stall;

  // an init tick ahead of the new word sets the start time this very cycle
  assign fwd_init  = valid_a && (item_a.opcode == OP_TICK) && !item_a.home_override &&
                     (phase == PH_INIT);
  assign start_eff = fwd_init ? item_a.now_ms : start_time;
  assign elapsed   = in_data.now_ms - start_eff;
  assign travel_next = TRAVEL_W'(speed) * TRAVEL_W'(elapsed);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
    end else if (cfg_we) begin
      speed <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (accept) begin
      valid_a <= 1'b1;
    end else if (adv) begin
      valid_a <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_a   <= in_data;
      travel_a <= travel_next;
    end
  end

  // estimate: trunc((start * D +/- travel) / D), floor or ceil of travel / D by sign case
  assign tw    = $signed({2'b00, travel_a});
  assign thr_x = {{(CMP_W-LIM_W){thr[LIM_W-1]}}, thr};
  assign lim_x = {{(CMP_W-LIM_W){lim[LIM_W-1]}}, lim};

  assign ok_floor = tw < (lim_x + CMP_W'(DIVISOR));
  assign ok_ceil  = tw <= lim_x;
  assign use_ceil = dir_forward ? (tw < thr_x) : (tw <= thr_x);
  assign ok       = use_ceil ? ok_ceil : ok_floor;

  assign qsrc    = travel_a[QSRC_HI:FRAC_SHIFT];
  assign rprod   = RPROD_W'(qsrc) * RPROD_W'(RECIP);
  assign quot    = rprod[RPROD_W-1:RECIP_SHIFT];
  assign quot125 = ((QSRC_W+1)'(quot) << 7) - ((QSRC_W+1)'(quot) << 1) - (QSRC_W+1)'(quot);
  assign rem_nz  = (|travel_a[FRAC_SHIFT-1:0]) || ((QSRC_W+1)'(qsrc) != quot125);
  assign adj     = quot + QUOT_W'(use_ceil && rem_nz);
  assign est     = dir_forward ? (start_pos + $signed(adj[POS_W-1:0]))
                               : (start_pos - $signed(adj[POS_W-1:0]));

  // thresholds latched on the init tick, fixed for the rest of the move
  assign cur_x = {current_pos[POS_W-1], current_pos};
  assign tgt_x = {target_pos[POS_W-1], target_pos};
  assign span  = dir_forward ? (tgt_x - cur_x) : (cur_x - tgt_x);
  assign base  = dir_forward ? -cur_x : cur_x;

  always_comb begin
    phase_next       = phase;
    dir_forward_next = dir_forward;
    target_pos_next  = target_pos;
    current_pos_next = current_pos;
    start_pos_next   = start_pos;
    start_time_next  = start_time;
    pin_a_next       = pin_a;
    pin_b_next       = pin_b;
    thr_next         = thr;
    lim_next         = lim;
    unique case (item_a.opcode)
      OP_MOVE: begin
        target_pos_next  = item_a.value;
        phase_next       = PH_INIT;
        dir_forward_next = item_a.value > current_pos;
      end
      OP_SET: begin
        current_pos_next = item_a.value;
      end
      OP_STOP: begin
        pin_a_next = 1'b0;
        pin_b_next = 1'b0;
        phase_next = PH_DONE;
      end
      OP_TICK: begin
        if (item_a.home_override) begin
          pin_a_next = 1'b1;
          pin_b_next = 1'b0;
        end else begin
          unique case (phase)
            PH_INIT: begin
              pin_a_next      = dir_forward;
              pin_b_next      = !dir_forward;
              start_time_next = item_a.now_ms;
              start_pos_next  = current_pos;
              thr_next        = mul_div(base);
              lim_next        = mul_div(span);
              phase_next      = PH_EXEC;
            end
            PH_EXEC: begin
              if (ok) begin
                current_pos_next = est;
              end else begin
                pin_a_next = 1'b0;
                pin_b_next = 1'b0;
                phase_next = PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DONE;
      dir_forward <= 1'b1;
      target_pos  <= '0;
      current_pos <= '0;
      start_pos   <= '0;
      start_time  <= '0;
      pin_a       <= 1'b0;
      pin_b       <= 1'b0;
    end else if (adv) begin
      phase       <= phase_next;
      dir_forward <= dir_forward_next;
      target_pos  <= target_pos_next;
      current_pos <= current_pos_next;
      start_pos   <= start_pos_next;
      start_time  <= start_time_next;
      pin_a       <= pin_a_next;
      pin_b       <= pin_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      thr <= thr_next;
      lim <= lim_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.drive_a  <= pin_a_next;
      out_data.drive_b  <= pin_b_next;
      out_data.position <= current_pos_next;
      out_data.finished <= (phase_next == PH_DONE);
    end
  end

endmodule

`default_nettype wire

@@ src/dcm_checker.sv @@
// port level checks for the timed move controller, bound to the top level
`default_nettype none

module dcm_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input dcm_pkg::out_word_t   out_data
);
  import dcm_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // a fresh result word follows a taken input word
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without a matching input word");

  // the bridge is never driven high on both sides
  a_no_shoot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.drive_a && out_data.drive_b))
    else $error("both bridge levels high");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

endmodule

bind dc_motor_timed_move_controller dcm_checker u_dcm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ bench/move_result_checker.sv @@
// checker for the timed move controller: tracks the controller state and compares each result word
`timescale 1ns / 1ps

module move_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  dcm_pkg::in_word_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  dcm_pkg::out_word_t           out_data,
  input  logic                         cfg_we,
  input  logic [dcm_pkg::SPEED_W-1:0]  cfg_data,
  output int                           fail_count,
  output int                           pending,
  output int                           checked,
  output int                           arrivals
);
  import dcm_pkg::*;

  // ms per second times the 8-bit speed fraction
  localparam longint MS_Q8_PER_UNIT = 256000;

  logic [SPEED_W-1:0]       speed;
  phase_t                   ph;
  logic                     fwd;
  logic signed [POS_W-1:0]  target;
  logic signed [POS_W-1:0]  cur;
  logic signed [POS_W-1:0]  origin;
  logic [TIME_W-1:0]        t_start;
  logic                     pin_a;
  logic                     pin_b;
  out_word_t                due_words[$];
  int                       reported;

  function automatic out_word_t advance_controller(input in_word_t w);
    logic [TIME_W-1:0] elapsed;
    longint            travel;
    longint            est;
    out_word_t         o;
    case (w.opcode)
      OP_MOVE: begin
        target = w.value;
        fwd = w.value > cur;
        ph = PH_INIT;
      end
      OP_SET: cur = w.value;
      OP_STOP: begin
        pin_a = 1'b0;
        pin_b = 1'b0;
        ph = PH_DONE;
      end
      default: begin
        if (w.home_override) begin
          pin_a = 1'b1;
          pin_b = 1'b0;
        end else if (ph == PH_INIT) begin
          pin_a = fwd;
          pin_b = !fwd;
          t_start = w.now_ms;
          origin = cur;
          ph = PH_EXEC;
        end else if (ph == PH_EXEC) begin
          // elapsed wraps with the time field, division truncates toward zero
          elapsed = w.now_ms - t_start;
          travel = longint'(speed) * longint'(elapsed);
          est = (longint'(origin) * MS_Q8_PER_UNIT + (fwd ? travel : -travel))
                / MS_Q8_PER_UNIT;
          if (fwd ? (est <= longint'(target)) : (est >= longint'(target))) begin
            cur = POS_W'(est);
          end else begin
            pin_a = 1'b0;
            pin_b = 1'b0;
            ph = PH_DONE;
            arrivals++;
          end
        end
      end
    endcase
    o.drive_a  = pin_a;
    o.drive_b  = pin_b;
    o.position = cur;
    o.finished = !(ph == PH_INIT || ph == PH_EXEC);
    return o;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      speed = '0;
      ph = PH_DONE;
      fwd = 1'b1;
      target = '0;
      cur = '0;
      origin = '0;
      t_start = '0;
      pin_a = 1'b0;
      pin_b = 1'b0;
      due_words.delete();
    end else begin
      if (cfg_we) begin
        speed = cfg_data;
      end
      if (in_valid && !in_stall) begin
        due_words.push_back(advance_controller(in_data));
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (due_words.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            $display("unexpected result word: a=%b b=%b pos=%0d fin=%b",
                     out_data.drive_a, out_data.drive_b, out_data.position, out_data.finished);
          end
          reported++;
        end else begin
          want = due_words.pop_front();
          if (out_data.drive_a !== want.drive_a || out_data.drive_b !== want.drive_b ||
              out_data.position !== want.position || out_data.finished !== want.finished) begin
            fail_count++;
            if (reported < 10) begin
              $display("mismatch on word %0d: expected a=%b b=%b pos=%0d fin=%b,",
                       checked, want.drive_a, want.drive_b, want.position, want.finished);
              $display("  got a=%b b=%b pos=%0d fin=%b",
                       out_data.drive_a, out_data.drive_b, out_data.position,
                       out_data.finished);
            end
            reported++;
          end
        end
      end
    end
    pending <= due_words.size();
  end

endmodule

@@ bench/dc_motor_timed_move_controller_tb.sv @@
// bench top for the timed move controller: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module dc_motor_timed_move_controller_tb;
  import dcm_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 70;
  localparam int N_PHASES    = 6;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;
  logic               cfg_we = 1'b0;
  logic [SPEED_W-1:0] cfg_data = '0;

  logic [SPEED_W-1:0] speed_now = '0;
  int                 fail_count;
  int                 pending;
  int                 checked;
  int                 arrivals;
  int                 settings;
  int                 words_sent;
  int                 cycles;
  bit                 gaps_on;
  bit                 stall_on;
  bit                 hold_go = 1'b0;
  bit                 hold_taken;
  int                 hold_left;
  int                 burst_left;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dc_motor_timed_move_controller i_dut (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data,
    .cfg_we,
    .cfg_data
  );

  move_result_checker i_chk (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data,
    .cfg_we,
    .cfg_data,
    .fail_count,
    .pending,
    .checked,
    .arrivals
  );

  // receiver: one long hold when asked, otherwise short random stall bursts
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (stall_on && !rst && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_word_t word_of(opcode_t op, logic signed [POS_W-1:0] v,
                                       logic [TIME_W-1:0] t, logic h);
    in_word_t w;
    w.opcode = op;
    w.value = v;
    w.now_ms = t;
    w.home_override = h;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_speed(input logic [SPEED_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    speed_now = v;
    settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // often a set, a move, the starting tick, then ticks spaced to cross the target
  task automatic run_move();
    logic signed [POS_W-1:0] from;
    logic signed [POS_W-1:0] dest;
    logic [TIME_W-1:0]       t;
    longint                  span;
    longint                  step;
    int                      gap;
    int                      n_ticks;
    int                      r;
    from = POS_W'($urandom);
    if ($urandom_range(0, 1)) begin
      dest = from + POS_W'($urandom_range(0, 400) - 200);
    end else begin
      dest = POS_W'($urandom);
    end
    if ($urandom_range(0, 9) == 0) begin
      dest = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    if ($urandom_range(0, 9) < 7) begin
      send_word(word_of(OP_SET, from, TIME_W'($urandom), 1'($urandom_range(0, 1))));
    end
    send_word(word_of(OP_MOVE, dest, TIME_W'($urandom), 1'($urandom_range(0, 1))));
    gap = int'(dest) - int'(from);
    if (gap < 0) begin
      gap = -gap;
    end
    gap++;
    span = (speed_now == 0) ? 1000 : longint'(gap) * 256000 / longint'(speed_now);
    if (span > longint'(32'hffff_ffff)) begin
      span = longint'(32'hffff_ffff);
    end
    n_ticks = $urandom_range(2, 12);
    step = span / n_ticks + 1;
    t = TIME_W'($urandom);
    send_word(word_of(OP_TICK, POS_W'($urandom), t, 1'b0));
    for (int i = 0; i < n_ticks + 2; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_word(word_of(OP_STOP, POS_W'($urandom), TIME_W'($urandom),
                          1'($urandom_range(0, 1))));
      end else if (r == 1) begin
        send_word(word_of(OP_TICK, POS_W'($urandom), t, 1'b1));
      end else if (r == 2) begin
        send_word(word_of(OP_TICK, POS_W'($urandom), t, 1'b0));
      end else begin
        t = t + TIME_W'(step * $urandom_range(50, 150) / 100);
        send_word(word_of(OP_TICK, POS_W'($urandom), t, 1'b0));
      end
    end
  endtask

  initial begin : stimulus
    int                 base;
    logic [SPEED_W-1:0] v;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero speed: moves never end by themselves
    write_speed('0);
    send_word(word_of(OP_TICK, 16'sh7fff, 32'hffff_ffff, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'h0000_0000, 1'b1));
    // move to the current position goes backward, home flag ignored off ticks
    send_word(word_of(OP_MOVE, 16'sh0000, 32'hffff_ffff, 1'b1));
    send_word(word_of(OP_TICK, 16'sh0000, 32'h0000_0000, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'd5000, 1'b0));
    send_word(word_of(OP_STOP, 16'sh8000, 32'h0000_0000, 1'b1));
    send_word(word_of(OP_SET, 16'sh8000, 32'hffff_ffff, 1'b0));
    send_word(word_of(OP_MOVE, 16'sh7fff, 32'h0000_0000, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'hffff_ff00, 1'b0));
    // home in the middle of a move keeps the move going
    send_word(word_of(OP_TICK, 16'sh0000, 32'hffff_ff80, 1'b1));
    send_word(word_of(OP_TICK, 16'sh0000, 32'h0000_0010, 1'b0));
    send_word(word_of(OP_STOP, 16'sh0000, 32'h0000_0000, 1'b0));
    drain(4);

    // top speed: one ms already overshoots short moves
    write_speed('1);
    send_word(word_of(OP_SET, 16'sh0000, 32'h0000_0000, 1'b0));
    send_word(word_of(OP_MOVE, -16'sd1, 32'h0000_0000, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'd100, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'd100, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'd101, 1'b0));
    send_word(word_of(OP_SET, 16'sh7fff, 32'h0000_0000, 1'b0));
    send_word(word_of(OP_MOVE, 16'sh8000, 32'h0000_0000, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'h0000_0000, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'hffff_ffff, 1'b0));
    send_word(word_of(OP_SET, -16'sd5, 32'h0000_0000, 1'b0));
    send_word(word_of(OP_MOVE, 16'sd10, 32'h0000_0000, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'd7, 1'b0));
    send_word(word_of(OP_TICK, 16'sh0000, 32'd10, 1'b0));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain(4);
      case (ph)
        0: v = 24'd256;
        1: v = SPEED_W'($urandom_range(0, 24'hff_ffff));
        2: v = 24'hff_ffff;
        3: v = SPEED_W'($urandom_range(1000, 200000));
        4: v = 24'd1;
        default: v = SPEED_W'($urandom_range(256, 65535));
      endcase
      write_speed(v);
      gaps_on = (ph % 3) != 1;
      stall_on = (ph % 3) != 2;
      if (ph == N_PHASES - 1) begin
        // clean finish with no idling at all
        gaps_on = 1'b0;
        stall_on = 1'b0;
      end
      if (ph == 2) begin
        hold_go <= 1'b1;
      end
      base = words_sent;
      while (words_sent - base < PHASE_WORDS) begin
        if ($urandom_range(0, 6) == 0) begin
          send_word(word_of(opcode_t'($urandom_range(0, 3)), POS_W'($urandom),
                            TIME_W'($urandom), 1'($urandom_range(0, 1))));
        end else begin
          run_move();
        end
      end
    end

    drain(8);
    $display("sent %0d input words over %0d speed settings, checked %0d result words",
             words_sent, settings, checked);
    $display("%0d moves ran past their target and stopped on their own", arrivals);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
